// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle implies a result in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/utv_pkg.sv =====
`default_nettype none

package utv_pkg;

  // Allowed range classes for the next continuation byte
  localparam int unsigned CLS_W = 3;
  localparam int unsigned NUM_CLS = 5;
  localparam logic [CLS_W-1:0] CLS_PLAIN = 3'd0;  // 80..BF
  localparam logic [CLS_W-1:0] CLS_E0    = 3'd1;  // A0..BF
  localparam logic [CLS_W-1:0] CLS_ED    = 3'd2;  // 80..9F
  localparam logic [CLS_W-1:0] CLS_F0    = 3'd3;  // 90..BF
  localparam logic [CLS_W-1:0] CLS_F4    = 3'd4;  // 80..8F

  localparam int unsigned PEND_W = 2;

  // Default depth of the queue between classifier and checker
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified item as it travels through the queue
  typedef struct packed {
    logic [NUM_CLS-1:0] cont_ok;     // byte fits continuation class n
    logic [PEND_W-1:0]  lead_count;  // continuation bytes a lead opens
    logic [CLS_W-1:0]   lead_class;  // class of the first continuation
    logic               lead_bad;    // byte cannot start a character
    logic               last_byte;
    logic               empty_string;
  } item_t;

  // Queue head as seen by the checker
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

`default_nettype wire

// ===== rtl/core/utv_front.sv =====
`default_nettype none

module utv_front (
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_byte,
  input  wire logic          empty_string,
  output utv_pkg::item_t     item
);

  logic single_ok;

  always_comb begin
    // Continuation ranges per class
    item.cont_ok = '0;
    item.cont_ok[utv_pkg::CLS_PLAIN] = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
    item.cont_ok[utv_pkg::CLS_E0]    = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
    item.cont_ok[utv_pkg::CLS_ED]    = (data_byte >= 8'h80) && (data_byte <= 8'h9F);
    item.cont_ok[utv_pkg::CLS_F0]    = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
    item.cont_ok[utv_pkg::CLS_F4]    = (data_byte >= 8'h80) && (data_byte <= 8'h8F);

    // Lead byte decode: tab, LF, CR, printable ASCII, or a multi-byte lead
    single_ok = (data_byte == 8'h09) || (data_byte == 8'h0A) || (data_byte == 8'h0D) ||
                ((data_byte >= 8'h20) && (data_byte <= 8'h7E));
    item.lead_count = '0;
    item.lead_class = utv_pkg::CLS_PLAIN;
    item.lead_bad   = 1'b0;
    if (single_ok) begin
      item.lead_count = '0;
    end else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF)) begin
      item.lead_count = 2'd1;
    end else if (data_byte == 8'hE0) begin
      item.lead_count = 2'd2;
      item.lead_class = utv_pkg::CLS_E0;
    end else if (data_byte == 8'hED) begin
      item.lead_count = 2'd2;
      item.lead_class = utv_pkg::CLS_ED;
    end else if ((data_byte >= 8'hE1) && (data_byte <= 8'hEF)) begin
      item.lead_count = 2'd2;
    end else if (data_byte == 8'hF0) begin
      item.lead_count = 2'd3;
      item.lead_class = utv_pkg::CLS_F0;
    end else if (data_byte == 8'hF4) begin
      item.lead_count = 2'd3;
      item.lead_class = utv_pkg::CLS_F4;
    end else if ((data_byte >= 8'hF1) && (data_byte <= 8'hF3)) begin
      item.lead_count = 2'd3;
    end else begin
      item.lead_bad = 1'b1;
    end
    item.last_byte    = last_byte;
    item.empty_string = empty_string;
  end

endmodule

`default_nettype wire

// ===== rtl/core/utv_queue.sv =====
`default_nettype none

`include "assert_macros.svh"

// Small FIFO of classified items; the user must keep DEPTH a power of two, 2 to 16 (not enforced here).
module utv_queue #(
  parameter int unsigned DEPTH = utv_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire utv_pkg::item_t push_item,
  output logic                full,
  output utv_pkg::head_t      head,
  input  wire logic           pop
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  utv_pkg::item_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_ALWAYS(a_ptr_gap, (wr_ptr - rd_ptr) == PTR_W'(count), "queue pointers off count")

endmodule

`default_nettype wire

// ===== rtl/core/utv_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module utv_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire utv_pkg::head_t head,
  output logic                pop,
  output logic                result_valid,
  output logic                result_bit,
  input  wire logic           result_ready
);

  logic [utv_pkg::PEND_W-1:0] pending_count, pending_count_next;
  logic [utv_pkg::CLS_W-1:0]  next_cont_class, next_cont_class_next;
  logic                       error_seen, error_seen_next;
  logic                       fits;
  logic                       ends;
  logic                       verdict;
  utv_pkg::item_t             it;

  assign it  = head.item;
  assign pop = head.valid && (!result_valid || result_ready);
  assign ends = it.empty_string || it.last_byte;

  // Continuation check for the stored class; unused codes act as plain
  always_comb begin
    case (next_cont_class)
      utv_pkg::CLS_E0: fits = it.cont_ok[utv_pkg::CLS_E0];
      utv_pkg::CLS_ED: fits = it.cont_ok[utv_pkg::CLS_ED];
      utv_pkg::CLS_F0: fits = it.cont_ok[utv_pkg::CLS_F0];
      utv_pkg::CLS_F4: fits = it.cont_ok[utv_pkg::CLS_F4];
      default:         fits = it.cont_ok[utv_pkg::CLS_PLAIN];
    endcase
  end

  // Sequence state update for one byte
  always_comb begin
    pending_count_next   = pending_count;
    next_cont_class_next = next_cont_class;
    error_seen_next      = error_seen;
    if (error_seen) begin
      error_seen_next = 1'b1;
    end else if (pending_count != '0) begin
      if (fits) begin
        pending_count_next   = pending_count - 2'd1;
        next_cont_class_next = utv_pkg::CLS_PLAIN;
      end else begin
        error_seen_next = 1'b1;
      end
    end else if (it.lead_bad) begin
      error_seen_next = 1'b1;
    end else begin
      pending_count_next   = it.lead_count;
      next_cont_class_next = it.lead_class;
    end
    verdict = it.empty_string || (!error_seen_next && (pending_count_next == '0));
  end

  // State registers: a string end returns everything to reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count   <= '0;
      next_cont_class <= utv_pkg::CLS_PLAIN;
      error_seen      <= 1'b0;
    end else if (pop) begin
      if (ends) begin
        pending_count   <= '0;
        next_cont_class <= utv_pkg::CLS_PLAIN;
        error_seen      <= 1'b0;
      end else begin
        pending_count   <= pending_count_next;
        next_cont_class <= next_cont_class_next;
        error_seen      <= error_seen_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && ends) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ends) result_bit <= verdict;
  end

  `ASSERT_NEXT(a_end_gives_result, pop && ends, result_valid, "string end without result")
  `ASSERT_NEXT(a_end_clears, pop && ends,
               pending_count == '0 && !error_seen && next_cont_class == utv_pkg::CLS_PLAIN,
               "state not cleared after string end")

endmodule

`default_nettype wire

// ===== rtl/core/utf8_text_validator_unit.sv =====
// Channel  | Dir | tdata                  | tlast     | tuser
// s_axis   | in  | [7:0] data_byte        | last_byte | [0] empty_string
// m_axis   | out | [0] string_valid, zero | -         | -
//
// One item is accepted per cycle while the queue is not full; the checker
// updates its sequence state as it pops each item.
// A result passes through the queue slot and then the output register
// before it is valid.
// Results appear only on items that end a string (last_byte or empty_string).
// Reset empties the queue, clears sequence state and drops any pending result.
// A stalled output holds the checker; the queue keeps input accepted until full.
`default_nettype none

module utf8_text_validator_unit #(
  parameter int unsigned QUEUE_DEPTH = utv_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,
  input  wire logic [0:0] s_axis_tuser,   // [0] empty_string
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] string_valid, [7:1] zero
);

  utv_pkg::item_t  cls_item;
  utv_pkg::head_t  head;
  logic            full;
  logic            pop;
  logic            result_bit;

  assign s_axis_tready = !full;
  assign m_axis_tdata  = {7'd0, result_bit};

  utv_front u_front (
    .data_byte    (s_axis_tdata),
    .last_byte    (s_axis_tlast),
    .empty_string (s_axis_tuser[0]),
    .item         (cls_item)
  );

  utv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_item (cls_item),
    .full      (full),
    .head      (head),
    .pop       (pop)
  );

  utv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (m_axis_tvalid),
    .result_bit   (result_bit),
    .result_ready (m_axis_tready)
  );

endmodule

`default_nettype wire
